// ===== src/rls_pkg.sv =====
package rls_pkg;

  localparam int LED_DEPTH_DEF = 256;
  localparam int BITS_PER_LED  = 24;
  localparam int COLOR_W       = 24;
  localparam logic [4:0] BIT_TOP = 5'(BITS_PER_LED - 1);

  // action codes
  localparam logic [1:0] ACT_SET_ONE = 2'd0;
  localparam logic [1:0] ACT_SET_ALL = 2'd1;
  localparam logic [1:0] ACT_TRIGGER = 2'd2;
  localparam logic [1:0] ACT_TICK    = 2'd3;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_LED_COUNT  = 3'd0;
  localparam logic [2:0] REG_PERIOD_TOP = 3'd1;
  localparam logic [2:0] REG_ONE_HIGH   = 3'd2;
  localparam logic [2:0] REG_ZERO_HIGH  = 3'd3;
  localparam logic [2:0] REG_RESET_SLOT = 3'd4;

  localparam logic [8:0] LED_COUNT_RST  = 9'd256;
  localparam logic [5:0] PERIOD_TOP_RST = 6'd29;
  localparam logic [5:0] ONE_HIGH_RST   = 6'd17;
  localparam logic [5:0] ZERO_HIGH_RST  = 6'd9;
  localparam logic [7:0] RESET_SLOT_RST = 8'd42;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic rejected;
  } res_t;

  // requests from the command decoder to the frame sequencer
  typedef struct packed {
    logic tick;
    logic trigger;
  } frm_req_t;

  // frame sequencer state as seen before the current transfer
  typedef struct packed {
    logic       sending;
    logic       in_data;
    logic [4:0] bit_sel;
    logic [5:0] tick_pos;
  } frm_stat_t;

  function automatic logic [COLOR_W-1:0] pack_grb(input cmd_t c);
    pack_grb = {c.green, c.red, c.blue};
  endfunction

endpackage

// ===== src/rls_color_mem.sv =====
module rls_color_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [rls_pkg::COLOR_W-1:0]  wdata,
  input  logic [AW-1:0]                raddr,
  output logic [rls_pkg::COLOR_W-1:0]  rdata
);
  import rls_pkg::*;

  logic [COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rls_frame_ctl.sv =====
module rls_frame_ctl #(
  parameter int LED_DEPTH = 256,
  parameter int AW        = 8,
  parameter int CW        = 9,
  parameter int SW        = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CW-1:0]       count,
  input  logic [5:0]          period_top,
  input  logic [7:0]          reset_slots,
  input  rls_pkg::frm_req_t   req,
  output rls_pkg::frm_stat_t  stat,
  output logic [AW-1:0]       rd_addr
);
  import rls_pkg::*;

  localparam logic [AW-1:0] LED_LAST = AW'(LED_DEPTH - 1);

  logic          sending;
  logic [SW-1:0] slot;
  logic [5:0]    tick_pos;
  logic [4:0]    bit_sel;
  logic [AW-1:0] led_ptr;

  logic [SW-1:0] data_slots;
  logic [SW-1:0] total;
  logic [SW-1:0] slot_inc;

  assign data_slots = SW'(count) * SW'(BITS_PER_LED);
  assign total      = data_slots + SW'(reset_slots);
  assign slot_inc   = slot + SW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sending  <= 1'b0;
      slot     <= '0;
      tick_pos <= '0;
      bit_sel  <= BIT_TOP;
      led_ptr  <= '0;
    end else if (req.trigger) begin
      sending  <= 1'b1;
      slot     <= '0;
      tick_pos <= '0;
      bit_sel  <= BIT_TOP;
      led_ptr  <= '0;
    end else if (req.tick && sending) begin
      if (slot >= total) begin
        sending <= 1'b0;
      end else if (tick_pos >= period_top) begin
        tick_pos <= '0;
        slot     <= slot_inc;
        if (bit_sel == 5'd0) begin
          bit_sel <= BIT_TOP;
          // hold at the last memory entry instead of wrapping
          if (led_ptr != LED_LAST) begin
            led_ptr <= led_ptr + AW'(1);
          end
        end else begin
          bit_sel <= bit_sel - 5'd1;
        end
        if (slot_inc >= total) begin
          sending <= 1'b0;
        end
      end else begin
        tick_pos <= tick_pos + 6'd1;
      end
    end
  end

  assign rd_addr       = led_ptr;
  assign stat.sending  = sending;
  assign stat.in_data  = sending && (slot < data_slots);
  assign stat.bit_sel  = bit_sel;
  assign stat.tick_pos = tick_pos;

endmodule

// ===== src/rgb_led_strip_driver.sv =====
// Channel   Ports                                     Transfer when
// command   start, busy, cmd (cmd_t)                  start && !busy at clk edge
// result    done, res (res_t)                         done high, one cycle only
// config    psel, penable, pwrite, paddr, pwdata,     psel && penable && pwrite
//           prdata, pready (always high)
//
// Each command gives its result in the cycle after the transfer. Set-one, trigger
// and tick leave busy low, so a new command may follow every clock while busy
// is low. Set-all walks the color memory at one write per cycle: busy stays high
// after the transfer until min(led_count, LED_DEPTH) entries have been written.
// After reset, busy is high while the memory is cleared; config writes are taken
// during that time. The result side cannot stall.
module rgb_led_strip_driver #(
  parameter int LED_DEPTH = rls_pkg::LED_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rls_pkg::cmd_t cmd,
  output logic          done,
  output rls_pkg::res_t res,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import rls_pkg::*;

  localparam int AW = (LED_DEPTH > 1) ? $clog2(LED_DEPTH) : 1;
  localparam int CW = $clog2(LED_DEPTH + 1);
  localparam int SW = $clog2(LED_DEPTH * BITS_PER_LED + 256);

  // configuration registers
  logic [8:0] led_count;
  logic [5:0] period_top;
  logic [5:0] one_high;
  logic [5:0] zero_high;
  logic [7:0] reset_slots;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count   <= LED_COUNT_RST;
      period_top  <= PERIOD_TOP_RST;
      one_high    <= ONE_HIGH_RST;
      zero_high   <= ZERO_HIGH_RST;
      reset_slots <= RESET_SLOT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LED_COUNT:  led_count   <= pwdata[8:0];
        REG_PERIOD_TOP: period_top  <= pwdata[5:0];
        REG_ONE_HIGH:   one_high    <= pwdata[5:0];
        REG_ZERO_HIGH:  zero_high   <= pwdata[5:0];
        REG_RESET_SLOT: reset_slots <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LED_COUNT:  prdata = {23'd0, led_count};
      REG_PERIOD_TOP: prdata = {26'd0, period_top};
      REG_ONE_HIGH:   prdata = {26'd0, one_high};
      REG_ZERO_HIGH:  prdata = {26'd0, zero_high};
      REG_RESET_SLOT: prdata = {24'd0, reset_slots};
      default:        prdata = '0;
    endcase
  end

  // LEDs in use
  logic [CW-1:0] count;
  always_comb begin
    if (32'(led_count) < 32'(LED_DEPTH)) begin
      count = CW'(led_count);
    end else begin
      count = CW'(LED_DEPTH);
    end
  end

  // command decode
  logic     accept;
  logic     set_one;
  logic     set_one_ok;
  logic     set_all;
  logic     trig;
  logic     tick;
  frm_req_t frm_req;
  frm_stat_t frm_stat;

  assign accept     = start && !busy;
  assign set_one    = accept && (cmd.action == ACT_SET_ONE);
  assign set_one_ok = set_one && (32'(cmd.led_index) < 32'(count));
  assign set_all    = accept && (cmd.action == ACT_SET_ALL);
  assign trig       = accept && (cmd.action == ACT_TRIGGER);
  assign tick       = accept && (cmd.action == ACT_TICK);

  assign frm_req.tick    = tick;
  assign frm_req.trigger = trig && !frm_stat.sending;

  // store walker: clear after reset, fill on set-all
  logic               walk_active;
  logic [AW-1:0]      walk_addr;
  logic [AW-1:0]      walk_last;
  logic [COLOR_W-1:0] walk_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active <= 1'b1;
      walk_addr   <= '0;
      walk_last   <= AW'(LED_DEPTH - 1);
      walk_data   <= '0;
    end else if (walk_active) begin
      walk_addr <= walk_addr + AW'(1);
      if (walk_addr == walk_last) begin
        walk_active <= 1'b0;
      end
    end else if (set_all && (count != '0)) begin
      walk_active <= 1'b1;
      walk_addr   <= '0;
      walk_last   <= AW'(count - CW'(1));
      walk_data   <= pack_grb(cmd);
    end
  end

  assign busy = walk_active;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [COLOR_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [COLOR_W-1:0] mem_rdata;

  always_comb begin
    if (walk_active) begin
      mem_we    = 1'b1;
      mem_waddr = walk_addr;
      mem_wdata = walk_data;
    end else begin
      mem_we    = set_one_ok;
      mem_waddr = AW'(cmd.led_index);
      mem_wdata = pack_grb(cmd);
    end
  end

  rls_color_mem #(
    .DEPTH (LED_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rls_frame_ctl #(
    .LED_DEPTH (LED_DEPTH),
    .AW        (AW),
    .CW        (CW),
    .SW        (SW)
  ) u_frame (
    .clk         (clk),
    .rst         (rst),
    .count       (count),
    .period_top  (period_top),
    .reset_slots (reset_slots),
    .req         (frm_req),
    .stat        (frm_stat),
    .rd_addr     (mem_raddr)
  );

  // result stage: color bit arrives from memory in the cycle after the transfer
  logic       rej_q;
  logic       lvl_en_q;
  logic [4:0] bit_q;
  logic [5:0] tick_q;
  logic [5:0] cmp;
  logic       color_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    rej_q    <= (set_one && !set_one_ok) || (trig && frm_stat.sending);
    lvl_en_q <= tick && frm_stat.in_data;
    bit_q    <= frm_stat.bit_sel;
    tick_q   <= frm_stat.tick_pos;
  end

  assign color_bit = mem_rdata[bit_q];
  assign cmp       = color_bit ? one_high : zero_high;

  assign res.line_level = lvl_en_q && (tick_q < cmp);
  assign res.busy_res   = frm_stat.sending;
  assign res.rejected   = rej_q;

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("no result after a command transfer");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without a command transfer");

  a_level_tick: assert property (@(posedge clk) disable iff (rst)
    done && res.line_level |-> $past(cmd.action == ACT_TICK))
    else $error("line high on a non-tick command");

  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd.action == ACT_TRIGGER) && frm_stat.sending |=> res.rejected)
    else $error("trigger during a frame not rejected");

  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    walk_active |-> walk_addr <= walk_last)
    else $error("store walk beyond its last entry");

endmodule
